// ===== design/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the streaming find-and-replace block
// Payload structs, configuration register map, sequencer states and byte
// selection helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    localparam int MAX_PATTERN_DEF     = 32;
    localparam int MAX_REPLACEMENT_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // pattern storage is four 64-bit words regardless of MAX_PATTERN
    localparam int PAT_BYTES = 32;
    localparam int PAT_BITS  = PAT_BYTES * 8;
    localparam int PAT_SEL_W = 5;
    localparam int PAT_IDX_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_WORD   = 3'd6;

    localparam logic [5:0]  PLEN_RESET  = 6'd1;
    localparam logic [3:0]  RLEN_RESET  = 4'd1;
    localparam logic [63:0] RWORD_RESET = 64'h2A;   // '*'

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_end;
    } t_out_item;

    typedef struct packed {
        logic [5:0]          plen;
        logic [PAT_BITS-1:0] pattern;
        logic [3:0]          rlen;
        logic [63:0]         rword;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CMP,
        S_REPL,
        S_EMIT,
        S_FL_RD,
        S_FL_EMIT,
        S_MARK
    } t_state;

    // pattern bytes past the stored words read as zero
    function automatic logic [7:0] pattern_byte(
        input logic [PAT_BITS-1:0]  pat,
        input logic [PAT_IDX_W-1:0] idx
    );
        logic [7:0] b;
        if (idx >= PAT_IDX_W'(PAT_BYTES)) begin
            b = 8'h00;
        end else begin
            b = pat[{idx[PAT_SEL_W-1:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] byte_of_word(
        input logic [63:0] w,
        input logic [2:0]  idx
    );
        return w[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== design/srs_cfg.sv =====
// ----------------------------------------------------------------------------
// srs_cfg: configuration register file
// Holds pattern, lengths and replacement; flags pattern writes so the
// sequencer can drop its pending bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_cfg
    import srs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg,
    output logic                       o_clear
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LENGTH:     n_cfg.plen          = i_cfg_data[5:0];
                REG_PATTERN_WORD_0:     n_cfg.pattern[63:0]    = i_cfg_data;
                REG_PATTERN_WORD_1:     n_cfg.pattern[127:64]  = i_cfg_data;
                REG_PATTERN_WORD_2:     n_cfg.pattern[191:128] = i_cfg_data;
                REG_PATTERN_WORD_3:     n_cfg.pattern[255:192] = i_cfg_data;
                REG_REPLACEMENT_LENGTH: n_cfg.rlen          = i_cfg_data[3:0];
                REG_REPLACEMENT_WORD:   n_cfg.rword         = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plen    <= PLEN_RESET;
            r_cfg.pattern <= '0;
            r_cfg.rlen    <= RLEN_RESET;
            r_cfg.rword   <= RWORD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        o_clear = i_cfg_we && (i_cfg_index inside {REG_PATTERN_LENGTH, REG_PATTERN_WORD_0,
                                                   REG_PATTERN_WORD_1, REG_PATTERN_WORD_2,
                                                   REG_PATTERN_WORD_3});
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/srs_buf.sv =====
// ----------------------------------------------------------------------------
// srs_buf: pending byte memory
// One write port, one registered read port; used as a circular buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_buf
    import srs_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(MAX_PATTERN)-1:0] i_waddr,
    input  wire logic [7:0]                     i_wdata,
    input  wire logic [$clog2(MAX_PATTERN)-1:0] i_raddr,
    output logic [7:0]                          o_rdata
);

    logic [7:0] r_mem [MAX_PATTERN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/srs_match.sv =====
// ----------------------------------------------------------------------------
// srs_match: shared byte compare unit
// Selects one pattern byte by position and compares it to a buffered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_match
    import srs_pkg::*;
(
    input  wire logic [PAT_BITS-1:0]  i_pattern,
    input  wire logic [PAT_IDX_W-1:0] i_index,
    input  wire logic [7:0]           i_data,
    output logic                      o_hit
);

    assign o_hit = (i_data == pattern_byte(i_pattern, i_index));

endmodule

`default_nettype wire

// ===== design/srs_seq.sv =====
// ----------------------------------------------------------------------------
// srs_seq: find-and-replace sequencer
// Appends each byte to the pending window, rechecks the window against the
// pattern one byte per compare, emits literals, replacements, the flush and end markers.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_seq
    import srs_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire t_in_item                       i_in_data,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output t_out_item                           o_out_data,
    input  wire t_cfg                           i_cfg,
    input  wire logic                           i_clear,
    output logic                                o_buf_we,
    output logic [$clog2(MAX_PATTERN)-1:0]      o_buf_waddr,
    output logic [7:0]                          o_buf_wdata,
    output logic [$clog2(MAX_PATTERN)-1:0]      o_buf_raddr,
    input  wire logic [7:0]                     i_buf_rdata,
    output logic [PAT_IDX_W-1:0]                o_cmp_index,
    input  wire logic                           i_cmp_hit
);

    localparam int AW = $clog2(MAX_PATTERN);
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int RW = $clog2(MAX_REPLACEMENT + 1);
    localparam logic [AW:0] DEPTH = (AW + 1)'(MAX_PATTERN);

    t_state      r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    logic [RW-1:0] r_k, n_k;
    logic        r_end, n_end;
    logic [7:0]  r_first, n_first;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;

    logic [CW-1:0] w_plen;
    logic [RW-1:0] w_rlen;
    logic [AW:0]   w_sum_rd, w_sum_wr, w_sum_inc;
    logic [AW-1:0] w_raddr, w_waddr, w_head_inc;
    logic          w_out_free;
    logic          w_last_j;
    logic          w_full;
    logic          w_last_k;

    // effective lengths: pattern at least one byte, both saturate
    always_comb begin
        if (i_cfg.plen == 6'd0) begin
            w_plen = CW'(1);
        end else if ({1'b0, i_cfg.plen} > 7'(MAX_PATTERN)) begin
            w_plen = CW'(MAX_PATTERN);
        end else begin
            w_plen = CW'(i_cfg.plen);
        end
        if (i_cfg.rlen > 4'(MAX_REPLACEMENT)) begin
            w_rlen = RW'(MAX_REPLACEMENT);
        end else begin
            w_rlen = RW'(i_cfg.rlen);
        end
    end

    // circular addressing; operands stay below twice the depth
    always_comb begin
        w_sum_rd   = {1'b0, r_head} + (AW + 1)'(r_j);
        w_sum_wr   = {1'b0, r_head} + (AW + 1)'(r_count);
        w_sum_inc  = {1'b0, r_head} + (AW + 1)'(1);
        w_raddr    = (w_sum_rd  >= DEPTH) ? AW'(w_sum_rd  - DEPTH) : w_sum_rd[AW-1:0];
        w_waddr    = (w_sum_wr  >= DEPTH) ? AW'(w_sum_wr  - DEPTH) : w_sum_wr[AW-1:0];
        w_head_inc = (w_sum_inc >= DEPTH) ? AW'(w_sum_inc - DEPTH) : w_sum_inc[AW-1:0];
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last_j   = (r_j + CW'(1)) == r_count;
    assign w_full     = r_count >= w_plen;
    assign w_last_k   = r_k == (w_rlen - RW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHK_RD;
                end
            end
            S_CHK_RD: n_state = S_CHK_CMP;
            S_CHK_CMP: begin
                if (!i_cmp_hit) begin
                    n_state = S_EMIT;
                end else if (w_last_j) begin
                    if (w_full) begin
                        n_state = S_REPL;
                    end else if (r_end) begin
                        n_state = S_FL_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_CHK_RD;
                end
            end
            S_REPL: begin
                if (w_rlen == '0) begin
                    n_state = r_end ? S_MARK : S_IDLE;
                end else if (w_out_free && w_last_k) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_count == CW'(1)) ? S_IDLE : S_CHK_RD;
                end
            end
            S_FL_RD: n_state = S_FL_EMIT;
            S_FL_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last_j ? S_IDLE : S_FL_RD;
                end
            end
            S_MARK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_j         = r_j;
        n_k         = r_k;
        n_end       = r_end;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_buf_we    = 1'b0;
        o_buf_wdata = i_in_data.text_byte;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_buf_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_end    = i_in_data.text_end;
                    n_j      = '0;
                end
            end
            S_CHK_CMP: begin
                if (r_j == '0) begin
                    n_first = i_buf_rdata;
                end
                if (i_cmp_hit) begin
                    n_j = r_j + CW'(1);
                    if (w_last_j) begin
                        if (w_full) begin
                            // only the whole window can match, so nothing went out before
                            n_count = '0;
                            n_head  = '0;
                            n_k     = '0;
                        end else if (r_end) begin
                            n_j = '0;
                        end
                    end
                end
            end
            S_REPL: begin
                if (w_rlen != '0 && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_byte: byte_of_word(i_cfg.rword, 3'(r_k)),
                                    byte_present: 1'b1,
                                    out_end: r_end && w_last_k};
                    n_k         = r_k + RW'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_byte: r_first, byte_present: 1'b1,
                                    out_end: r_end && (r_count == CW'(1))};
                    n_head      = w_head_inc;
                    n_count     = r_count - CW'(1);
                    n_j         = '0;
                end
            end
            S_FL_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_byte: i_buf_rdata, byte_present: 1'b1,
                                    out_end: w_last_j};
                    n_j         = r_j + CW'(1);
                    if (w_last_j) begin
                        n_count = '0;
                        n_head  = '0;
                    end
                end
            end
            S_MARK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_byte: 8'h00, byte_present: 1'b0, out_end: 1'b1};
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase

        // pattern rewrite drops pending bytes
        if (i_clear) begin
            n_count = '0;
            n_head  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_j         <= n_j;
            r_k         <= n_k;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_out_data <= n_out_data;
    end

    assign o_buf_waddr = w_waddr;
    assign o_buf_raddr = w_raddr;
    assign o_cmp_index = PAT_IDX_W'(r_j);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== design/substring_replace_stream_top.sv =====
// ----------------------------------------------------------------------------
// substring_replace_stream_top: streaming find-and-replace
// Replaces each leftmost non-overlapping occurrence of a pattern in a byte
// stream with a replacement string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one text byte per request,
//   with text_end on the last byte of a text. Output channel
//   (o_out_valid/i_out_ready) gives the rewritten bytes; out_end marks the
//   last result of a text, a bare end marker has byte_present low.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while
//   the block is idle; a pattern write drops pending bytes.
//   One request is worked on at a time. A byte that mismatches with nothing
//   pending goes through a memory read, a compare and an emit before ready
//   returns; a byte that only extends the window, through the recheck. Each
//   recheck of the pending window reads, then compares, one pending byte at a
//   time in the shared byte comparator, and each emitted byte waits for a free
//   output register, so a mismatch after k pending bytes costs on the order of
//   k*k compares. A flush reads and emits one pending byte at a time.
//   Reset clears the pending window and loads the default configuration
//   (pattern length 1, pattern 0x00, replacement "*"). When the receiver
//   stalls, the output register holds its result and the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_replace_stream_top
    import srs_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_PATTERN);

    t_cfg          w_cfg;
    logic          w_clear;
    logic          w_buf_we;
    logic [AW-1:0] w_buf_waddr;
    logic [7:0]    w_buf_wdata;
    logic [AW-1:0] w_buf_raddr;
    logic [7:0]    w_buf_rdata;
    logic [PAT_IDX_W-1:0] w_cmp_index;
    logic          w_cmp_hit;

    srs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_clear     (w_clear)
    );

    srs_buf #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (w_buf_wdata),
        .i_raddr (w_buf_raddr),
        .o_rdata (w_buf_rdata)
    );

    srs_match u_match (
        .i_pattern (w_cfg.pattern),
        .i_index   (w_cmp_index),
        .i_data    (w_buf_rdata),
        .o_hit     (w_cmp_hit)
    );

    srs_seq #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg       (w_cfg),
        .i_clear     (w_clear),
        .o_buf_we    (w_buf_we),
        .o_buf_waddr (w_buf_waddr),
        .o_buf_wdata (w_buf_wdata),
        .o_buf_raddr (w_buf_raddr),
        .i_buf_rdata (w_buf_rdata),
        .o_cmp_index (w_cmp_index),
        .i_cmp_hit   (w_cmp_hit)
    );

endmodule

`default_nettype wire

// ===== design/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the find-and-replace block
// Watches the top level's channels; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_checker
    import srs_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_out_item o_out_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accept");

    // bare end marker is zero and final
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_present |->
            o_out_data.out_end && (o_out_data.out_byte == 8'h00))
        else $error("malformed bare end marker");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind substring_replace_stream_top srs_checker u_srs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_data  (o_out_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
